### rtl/arpc_pkg.sv
// Package for the ARP cache with entry aging: action codes, widths and the
// request record that travels down the cell chain. No dependencies.
`default_nettype none

package arpc_pkg;

    localparam int ARPC_CAPACITY = 64;
    localparam int IP_W          = 32;
    localparam int MAC_W         = 48;
    localparam int TIME_W        = 32;
    localparam int TMO_W         = 16;
    localparam int SLOT_W        = 6;
    localparam logic [TMO_W-1:0] TMO_RESET = 16'd15;

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    // Request record handed from cell to cell, one hop per cycle.
    typedef struct packed {
        logic              vld;
        t_action           action;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] now;
        logic [TMO_W-1:0]  timeout;
        logic              claimed;   // lookup hit or insert placed
        logic [SLOT_W-1:0] slot;
        logic [MAC_W-1:0]  hit_mac;
    } t_wave;

    typedef struct packed {
        logic              hit;
        logic [MAC_W-1:0]  mac_out;
        logic [SLOT_W-1:0] slot;
        logic              table_full;
    } t_rsp;

endpackage

`default_nettype wire

### rtl/arpc_if.sv
// Request and response channel interfaces for the ARP cache.
// Depends on arpc_pkg.
`default_nettype none

interface arpc_req_if import arpc_pkg::*; ;
    logic                 valid;
    logic                 ready;
    t_action              action;
    logic [IP_W-1:0]      ip_addr;
    logic [MAC_W-1:0]     mac_addr;

    modport source (output valid, action, ip_addr, mac_addr, input ready);
    modport sink   (input valid, action, ip_addr, mac_addr, output ready);
endinterface

interface arpc_rsp_if import arpc_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [MAC_W-1:0]     mac_out;
    logic [SLOT_W-1:0]    slot;
    logic                 table_full;

    modport source (output valid, hit, mac_out, slot, table_full, input ready);
    modport sink   (input valid, hit, mac_out, slot, table_full, output ready);
endinterface

`default_nettype wire

### rtl/arpc_cell.sv
// One table entry of the ARP cache plus its hop register of the request chain.
// Depends on arpc_pkg.
`default_nettype none

module arpc_cell import arpc_pkg::*; #(
    parameter int INDEX = 0
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire t_wave i_wave,
    output t_wave      o_wave
);

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);

    logic              r_valid;
    logic [IP_W-1:0]   r_ip;
    logic [MAC_W-1:0]  r_mac;
    logic [TIME_W-1:0] r_time;
    t_wave             r_wave;

    t_wave             n_wave;
    logic              n_valid;
    logic              wr_entry;
    logic [TIME_W-1:0] age;

    always_comb begin
        n_wave   = i_wave;
        n_valid  = r_valid;
        wr_entry = 1'b0;
        age      = i_wave.now - r_time;
        if (i_wave.vld) begin
            case (i_wave.action)
                ACT_LOOKUP: begin
                    // later cells overwrite: highest matching index wins
                    if (r_valid && (r_ip == i_wave.ip)) begin
                        n_wave.claimed = 1'b1;
                        n_wave.slot    = MY_SLOT;
                        n_wave.hit_mac = r_mac;
                    end
                end
                ACT_INSERT: begin
                    // first free cell takes the entry
                    if (!i_wave.claimed && !r_valid) begin
                        n_wave.claimed = 1'b1;
                        n_wave.slot    = MY_SLOT;
                        n_valid        = 1'b1;
                        wr_entry       = 1'b1;
                    end
                end
                ACT_TICK: begin
                    if (r_valid && (age > {{(TIME_W-TMO_W){1'b0}}, i_wave.timeout})) begin
                        n_valid = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_wave.vld <= 1'b0;
        end else begin
            r_valid    <= n_valid;
            r_wave.vld <= n_wave.vld;
        end
        r_wave.action  <= n_wave.action;
        r_wave.ip      <= n_wave.ip;
        r_wave.mac     <= n_wave.mac;
        r_wave.now     <= n_wave.now;
        r_wave.timeout <= n_wave.timeout;
        r_wave.claimed <= n_wave.claimed;
        r_wave.slot    <= n_wave.slot;
        r_wave.hit_mac <= n_wave.hit_mac;
        if (wr_entry) begin
            r_ip   <= i_wave.ip;
            r_mac  <= i_wave.mac;
            r_time <= i_wave.now;
        end
    end

    assign o_wave = r_wave;

endmodule

`default_nettype wire

### rtl/arp_cache_table_with_aging_core.sv
// Top level of the ARP cache with entry aging: seconds counter, timeout
// register, request launch, the chain of arpc_cell entries and the result stage.
// Depends on arpc_pkg, arpc_if and arpc_cell.
//
//   channel  | dir | handshake       | carries
//   ---------+-----+-----------------+----------------------------------------
//   i_req    | in  | valid / ready   | action, ip_addr, mac_addr
//   o_rsp    | out | valid / ready   | hit, mac_out, slot, table_full
//   i_cfg_*  | in  | write enable    | timeout_seconds (16 bits)
//
// A request walks the cell chain one cell per cycle, then is registered in the
// park register and moves on to the response register; the next request is
// accepted only once the previous result has left the park register. One
// request is in the chain at a time.
// Reset (synchronous, active low) clears every entry's valid bit at once,
// zeroes the seconds counter and loads timeout 15; no clearing pass.
// The response register holds while o_rsp.ready is low; the next request is
// taken the cycle after the previous result has moved into that register.
`default_nettype none

module arp_cache_table_with_aging_core import arpc_pkg::*; #(
    parameter int CAPACITY = ARPC_CAPACITY
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    arpc_req_if.sink          i_req,
    arpc_rsp_if.source        o_rsp,
    input  wire               i_cfg_we,
    input  wire [TMO_W-1:0]   i_cfg_data
);

    // Control state
    logic              r_busy;      // request in chain or parked, not yet in output
    logic              r_park_vld;
    logic              r_out_vld;
    logic [TIME_W-1:0] r_now;
    logic [TMO_W-1:0]  r_timeout;

    // Payload
    t_rsp              r_park;
    t_rsp              r_out;

    t_wave             wave [CAPACITY+1];
    logic              req_acc;
    logic              out_free;
    logic              park_move;
    logic [TIME_W-1:0] n_now;
    t_rsp              fin;

    assign i_req.ready = !r_busy;
    assign req_acc     = i_req.valid && !r_busy;
    assign out_free    = !r_out_vld || o_rsp.ready;
    assign park_move   = r_park_vld && out_free;

    // advance the clock before the age check on a tick
    assign n_now = (i_req.action == ACT_TICK) ? (r_now + 1'b1) : r_now;

    // launch record into the first cell
    always_comb begin
        wave[0].vld     = req_acc;
        wave[0].action  = i_req.action;
        wave[0].ip      = i_req.ip_addr;
        wave[0].mac     = i_req.mac_addr;
        wave[0].now     = n_now;
        wave[0].timeout = r_timeout;
        wave[0].claimed = 1'b0;
        wave[0].slot    = '0;
        wave[0].hit_mac = '0;
    end

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        arpc_cell #(
            .INDEX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wave  (wave[k]),
            .o_wave  (wave[k+1])
        );
    end

    // shape the result from the record leaving the last cell
    always_comb begin
        fin = '0;
        case (wave[CAPACITY].action)
            ACT_LOOKUP: begin
                if (wave[CAPACITY].claimed) begin
                    fin.hit     = 1'b1;
                    fin.mac_out = wave[CAPACITY].hit_mac;
                    fin.slot    = wave[CAPACITY].slot;
                end
            end
            ACT_INSERT: begin
                fin.slot       = wave[CAPACITY].slot;
                fin.table_full = !wave[CAPACITY].claimed;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_park_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_now      <= '0;
            r_timeout  <= TMO_RESET;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            if (req_acc) begin
                r_busy <= 1'b1;
                r_now  <= n_now;
            end else if (park_move) begin
                r_busy <= 1'b0;
            end
            if (wave[CAPACITY].vld) begin
                r_park_vld <= 1'b1;
            end else if (park_move) begin
                r_park_vld <= 1'b0;
            end
            if (park_move) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wave[CAPACITY].vld) begin
            r_park <= fin;
        end
        if (park_move) begin
            r_out <= r_park;
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.hit        = r_out.hit;
    assign o_rsp.mac_out    = r_out.mac_out;
    assign o_rsp.slot       = r_out.slot;
    assign o_rsp.table_full = r_out.table_full;

endmodule

`default_nettype wire

### rtl/arpc_checker.sv
// Port-level checks for the ARP cache core, bound to its top level.
// Depends on arpc_pkg and arp_cache_table_with_aging_core.
`default_nettype none

module arpc_checker import arpc_pkg::*; (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              req_valid,
    input wire              req_ready,
    input wire              rsp_valid,
    input wire              rsp_ready,
    input wire              rsp_hit,
    input wire [MAC_W-1:0]  rsp_mac,
    input wire [SLOT_W-1:0] rsp_slot,
    input wire              rsp_full
);

    // one request at a time: ready drops right after an acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while another is in the chain");

    a_miss_mac_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp_valid && !rsp_hit) |-> (rsp_mac == '0))
        else $error("nonzero MAC on a response without a hit");

    a_hit_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp_valid && rsp_hit) |-> !rsp_full)
        else $error("hit and table full on one response");

    a_full_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp_valid && rsp_full) |-> (rsp_slot == '0))
        else $error("table full response with nonzero slot");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_mac) && $stable(rsp_slot)))
        else $error("stalled response changed");

endmodule

bind arp_cache_table_with_aging_core arpc_checker u_arpc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .req_valid (i_req.valid),
    .req_ready (i_req.ready),
    .rsp_valid (o_rsp.valid),
    .rsp_ready (o_rsp.ready),
    .rsp_hit   (o_rsp.hit),
    .rsp_mac   (o_rsp.mac_out),
    .rsp_slot  (o_rsp.slot),
    .rsp_full  (o_rsp.table_full)
);

`default_nettype wire
